FILE: rtl/sync_header_color_packet_parser_defines.svh
// ---------------------------------------------------------------------------
// sync_header_color_packet_parser_defines
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef SYNC_HEADER_COLOR_PACKET_PARSER_DEFINES_SVH
`define SYNC_HEADER_COLOR_PACKET_PARSER_DEFINES_SVH

// Checked at every clk edge outside reset.
`define SHCPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clk edge, reset included.
`define SHCPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/shcpp_pkg.sv
// ---------------------------------------------------------------------------
// shcpp_pkg
// Types and constants for the sync-header color packet parser.
// ---------------------------------------------------------------------------
`default_nettype none

package shcpp_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 16;

  // Slot being filled; anything at or above POS_HUNT means hunting.
  typedef enum logic [2:0] {
    POS_LAMP  = 3'd0,
    POS_TIME  = 3'd1,
    POS_RED   = 3'd2,
    POS_GREEN = 3'd3,
    POS_BLUE  = 3'd4,
    POS_HUNT  = 3'd5
  } pos_t;

  // Packed with lamp_number in the lowest bits.
  typedef struct packed {
    logic [WORD_W-1:0] blue_level;
    logic [WORD_W-1:0] green_level;
    logic [WORD_W-1:0] red_level;
    logic [BYTE_W-1:0] fade_time;
    logic [BYTE_W-1:0] lamp_number;
  } packet_t;

  localparam int unsigned PACKET_W = $bits(packet_t);

endpackage

`default_nettype wire

FILE: rtl/shcpp_parser.sv
// ---------------------------------------------------------------------------
// shcpp_parser
// Header hunt and field capture; one byte per cycle while byte_valid is high.
// ---------------------------------------------------------------------------
`default_nettype none

module shcpp_parser
  import shcpp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_valid,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output logic                   pkt_push,
  output packet_t                pkt
);

  pos_t              pos_r,      pos_nxt;
  logic [BYTE_W-1:0] prev_r,     prev_nxt;
  logic              hi_r,       hi_nxt;
  logic [BYTE_W-1:0] lamp_r,     lamp_nxt;
  logic [BYTE_W-1:0] fade_r,     fade_nxt;
  logic [WORD_W-1:0] red_r,      red_nxt;
  logic [WORD_W-1:0] green_r,    green_nxt;
  logic [BYTE_W-1:0] blue_hi_r,  blue_hi_nxt;

  always_comb begin
    pos_nxt     = pos_r;
    prev_nxt    = prev_r;
    hi_nxt      = hi_r;
    lamp_nxt    = lamp_r;
    fade_nxt    = fade_r;
    red_nxt     = red_r;
    green_nxt   = green_r;
    blue_hi_nxt = blue_hi_r;
    pkt_push    = 1'b0;
    if (byte_valid) begin
      unique case (pos_r)
        POS_LAMP: begin
          lamp_nxt = rx_byte;
          pos_nxt  = POS_TIME;
        end
        POS_TIME: begin
          fade_nxt = rx_byte;
          pos_nxt  = POS_RED;
        end
        POS_RED: begin
          hi_nxt = !hi_r;
          if (!hi_r) begin
            red_nxt = {rx_byte, {BYTE_W{1'b0}}};
          end else begin
            red_nxt = {red_r[WORD_W-1:BYTE_W], rx_byte};
            pos_nxt = POS_GREEN;
          end
        end
        POS_GREEN: begin
          hi_nxt = !hi_r;
          if (!hi_r) begin
            green_nxt = {rx_byte, {BYTE_W{1'b0}}};
          end else begin
            green_nxt = {green_r[WORD_W-1:BYTE_W], rx_byte};
            pos_nxt   = POS_BLUE;
          end
        end
        POS_BLUE: begin
          hi_nxt = !hi_r;
          if (!hi_r) begin
            blue_hi_nxt = rx_byte;
          end else begin
            pos_nxt  = POS_HUNT;
            pkt_push = 1'b1;
          end
        end
        default: begin
          // hunting: two fresh 0xFF bytes open a packet
          if (prev_r == HEADER_BYTE && rx_byte == HEADER_BYTE) begin
            pos_nxt  = POS_LAMP;
            prev_nxt = '0;
          end else begin
            prev_nxt = rx_byte;
          end
        end
      endcase
    end
  end

  assign pkt.lamp_number = lamp_r;
  assign pkt.fade_time   = fade_r;
  assign pkt.red_level   = red_r;
  assign pkt.green_level = green_r;
  assign pkt.blue_level  = {blue_hi_r, rx_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HUNT;
      prev_r <= '0;
      hi_r   <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      prev_r <= prev_nxt;
      hi_r   <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lamp_r    <= lamp_nxt;
    fade_r    <= fade_nxt;
    red_r     <= red_nxt;
    green_r   <= green_nxt;
    blue_hi_r <= blue_hi_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/shcpp_obuf.sv
// ---------------------------------------------------------------------------
// shcpp_obuf
// Result register plus skid register; keeps input ready off out_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module shcpp_obuf
  import shcpp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire packet_t push_data,
  output logic         room,
  output logic         out_valid,
  output packet_t      out_data,
  input  wire logic    out_ready
);

  logic    out_valid_r,  out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  packet_t out_data_r,   out_data_nxt;
  packet_t skid_data_r,  skid_data_nxt;
  logic    pop;

  assign pop = out_valid_r && out_ready;

  // push must only happen while the skid slot is empty; this block does not enforce it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (out_valid_r && !pop) begin
      if (push) begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else begin
      out_valid_nxt = push;
      if (push) begin
        out_data_nxt = push_data;
      end
    end
  end

  assign room      = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/sync_header_color_packet_parser.sv
// ---------------------------------------------------------------------------
// sync_header_color_packet_parser
// Finds a two-byte 0xFF header in a serial byte stream and assembles the
// following lamp, fade time and RGB words into one packet transaction.
// ---------------------------------------------------------------------------
//
//   channel | dir | tdata                         | notes
//   --------+-----+-------------------------------+---------------------------
//   in_     | in  | [7:0] rx_byte                 | one serial byte/transaction
//   out_    | out | lamp, fade, red, green, blue  | one per completed packet
//
// - Throughput: one byte per cycle while in_tready is high; each byte is
//   handled in the cycle it is accepted, and each packet is then registered.
// - A packet takes 8 input transactions after the header: lamp, fade, then
//   three 16-bit words high byte first.
// - Output stalls are absorbed by a result register and a skid register;
//   in_tready drops only when both hold a packet.
// - Synchronous active-low reset returns the parser to header hunting.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_header_color_packet_parser
  import shcpp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // slave side
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [BYTE_W-1:0]   in_tdata,   // [7:0] rx_byte
  // master side
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [PACKET_W-1:0]      out_tdata   // [7:0] lamp_number,
                                               // [15:8] fade_time,
                                               // [31:16] red_level,
                                               // [47:32] green_level,
                                               // [63:48] blue_level
);

  logic    in_accept;
  logic    pkt_push;
  packet_t pkt;
  packet_t out_pkt;

  assign in_accept = in_tvalid && in_tready;

  // Byte parser: state registers feed a short decode; the packet is valid on
  // pkt_push in the cycle the blue low byte is accepted.
  shcpp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_accept),
    .rx_byte    (in_tdata),
    .pkt_push   (pkt_push),
    .pkt        (pkt)
  );

  // Output stage; 'room' guarantees a slot for any packet pushed this cycle.
  shcpp_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pkt_push),
    .push_data (pkt),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_data  (out_pkt),
    .out_ready (out_tready)
  );

  assign out_tdata = out_pkt;

endmodule

`default_nettype wire

FILE: rtl/shcpp_checker.sv
// ---------------------------------------------------------------------------
// shcpp_checker
// Port-level checks for the sync-header color packet parser.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sync_header_color_packet_parser_defines.svh"

module shcpp_checker
  import shcpp_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_tvalid,
  input wire logic                in_tready,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [PACKET_W-1:0] out_tdata
);

  `SHCPP_ASSERT(a_out_hold,
                out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata),
                "stalled result dropped or changed")
  `SHCPP_ASSERT_ALWAYS(a_reset_clear,
                       !rst_n |=> !out_tvalid && in_tready,
                       "reset left output or input blocked")
  `SHCPP_ASSERT(a_rise_needs_byte,
                $rose(out_tvalid) |-> $past(in_tvalid && in_tready),
                "result without an accepted byte")
  `SHCPP_ASSERT(a_backpressure, !in_tready |-> out_tvalid, "input stalled with empty output")

endmodule

bind sync_header_color_packet_parser shcpp_checker u_shcpp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
